// ===== rtl/core/brc_pkg.sv =====
`timescale 1ns / 1ps

package brc_pkg;

    // number of bisection steps on x(t) = sample
    localparam int BISECT_STEPS = 20;

    localparam int Q_W     = 17;              // unsigned Q1.16
    localparam int T_FRAC  = 24;              // t is Q1.24 (24 fraction bits)
    localparam int T_W     = T_FRAC + 1;      // holds 1.0 as well
    localparam int SQ_W    = 2 * T_W;
    localparam int PROD_W  = T_W + Q_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int IDX_W   = 3;

    localparam logic [Q_W-1:0] Q_ONE  = Q_W'(65536);
    localparam logic [Q_W-1:0] Q_HALF = Q_W'(32768);
    localparam logic [T_W-1:0] T_ONE  = T_W'(1) << T_FRAC;
    localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (T_FRAC - 1);

    typedef enum logic [IDX_W-1:0] {
        CFG_START_Y      = 3'd0,
        CFG_LEFT_CTRL_X  = 3'd1,
        CFG_LEFT_CTRL_Y  = 3'd2,
        CFG_CENTER_Y     = 3'd3,
        CFG_RIGHT_CTRL_X = 3'd4,
        CFG_RIGHT_CTRL_Y = 3'd5,
        CFG_END_Y        = 3'd6
    } cfg_idx_t;

    // clamped curve controls
    typedef struct packed {
        logic [Q_W-1:0] lcx;
        logic [Q_W-1:0] rcx;
        logic [Q_W-1:0] sy;
        logic [Q_W-1:0] ly;
        logic [Q_W-1:0] cy;
        logic [Q_W-1:0] ry;
        logic [Q_W-1:0] ey;
    } ctrl_t;

    typedef struct packed {
        logic [Q_W-1:0] p0;
        logic [Q_W-1:0] p1;
        logic [Q_W-1:0] p2;
    } pts_t;

    // classified sample: seg set selects the right segment
    typedef struct packed {
        logic           seg;
        logic [Q_W-1:0] x;
    } front_item_t;

    // bisection interval in flight
    typedef struct packed {
        logic           seg;
        logic [Q_W-1:0] x;
        logic [T_W-1:0] low;
        logic [T_W-1:0] high;
    } bis_t;

    typedef struct packed {
        bis_t           b;
        logic [T_W-1:0] mid;
        logic [T_W-1:0] w0;
        logic [T_W-1:0] w1;
        logic [T_W-1:0] w2;
    } wgt_t;

    typedef struct packed {
        bis_t              b;
        logic [T_W-1:0]    mid;
        logic [PROD_W-1:0] pr0;
        logic [PROD_W-1:0] pr1;
        logic [PROD_W-1:0] pr2;
    } prd_t;

    function automatic pts_t x_pts(input ctrl_t c, input logic seg);
        pts_t p;
        if (seg)
        begin
            p.p0 = Q_HALF;
            p.p1 = c.rcx;
            p.p2 = Q_ONE;
        end
        else
        begin
            p.p0 = '0;
            p.p1 = c.lcx;
            p.p2 = Q_HALF;
        end
        return p;
    endfunction

    function automatic pts_t y_pts(input ctrl_t c, input logic seg);
        pts_t p;
        if (seg)
        begin
            p.p0 = c.cy;
            p.p1 = c.ry;
            p.p2 = c.ey;
        end
        else
        begin
            p.p0 = c.sy;
            p.p1 = c.ly;
            p.p2 = c.cy;
        end
        return p;
    endfunction

endpackage

// ===== rtl/core/brc_if.sv =====
`timescale 1ns / 1ps

interface brc_sample_if;
    import brc_pkg::*;
    logic           valid;
    logic           ready;
    logic [Q_W-1:0] sample_in;
    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

interface brc_result_if;
    import brc_pkg::*;
    logic           valid;
    logic           ready;
    logic [Q_W-1:0] shaped_out;
    modport source (output valid, output shaped_out, input ready);
    modport sink (input valid, input shaped_out, output ready);
endinterface

interface brc_cfg_if;
    import brc_pkg::*;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [Q_W-1:0]   data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/brc_front.sv =====
`timescale 1ns / 1ps

module brc_front
    import brc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    brc_sample_if.sink      sample,
    output logic            out_valid,
    input  logic            out_ready,
    output front_item_t     out_item
);

    logic        valid_reg, valid_next;
    front_item_t item_reg, item_next;
    logic [Q_W-1:0] x_clamped;

    assign sample.ready = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign out_item     = item_reg;

    always_comb
    begin
        // saturate to 1.0, then pick the segment
        x_clamped      = (sample.sample_in > Q_ONE) ? Q_ONE : sample.sample_in;
        item_next.x    = x_clamped;
        item_next.seg  = (x_clamped > Q_HALF);
        valid_next     = valid_reg;
        if (sample.ready)
        begin
            valid_next = sample.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== rtl/core/brc_queue.sv =====
`timescale 1ns / 1ps

module brc_queue
    import brc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  front_item_t in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output front_item_t out_item
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    front_item_t      mem [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != (PTR_W+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/brc_back.sv =====
`timescale 1ns / 1ps

module brc_back
    import brc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  front_item_t in_item,
    input  ctrl_t       ctrl,
    brc_result_if.source result
);

    logic           adv;
    logic           out_valid_reg, out_valid_next;
    logic [Q_W-1:0] out_data_reg, out_data_next;

    logic stg_vld [0:BISECT_STEPS];
    bis_t stg_dat [0:BISECT_STEPS];

    // whole pipeline moves together, held only by the output register
    assign adv       = !out_valid_reg || result.ready;
    assign in_ready  = adv;
    assign result.valid      = out_valid_reg;
    assign result.shaped_out = out_data_reg;

    assign stg_vld[0]      = in_valid;
    assign stg_dat[0].seg  = in_item.seg;
    assign stg_dat[0].x    = in_item.x;
    assign stg_dat[0].low  = '0;
    assign stg_dat[0].high = T_ONE;

    for (genvar s = 0; s <= BISECT_STEPS; s++)
    begin : g_step
        localparam bit IS_EVAL = (s == BISECT_STEPS);

        logic a_vld_reg;
        wgt_t a_reg, a_next;
        logic b_vld_reg;
        prd_t b_reg, b_next;

        // weights at the interval midpoint
        always_comb
        begin
            logic [T_W:0]    lh;
            logic [T_W-1:0]  t;
            logic [T_W-1:0]  u;
            logic [SQ_W-1:0] uu;
            logic [SQ_W-1:0] tt;
            lh = {1'b0, stg_dat[s].low} + {1'b0, stg_dat[s].high};
            t  = lh[T_W:1];
            u  = T_ONE - t;
            uu = SQ_W'(u) * SQ_W'(u);
            tt = SQ_W'(t) * SQ_W'(t);
            a_next.b   = stg_dat[s];
            a_next.mid = t;
            a_next.w0  = uu[T_FRAC +: T_W];
            a_next.w2  = tt[T_FRAC +: T_W];
            a_next.w1  = T_ONE - a_next.w0 - a_next.w2;
        end

        // weighted points
        always_comb
        begin
            pts_t p;
            p = IS_EVAL ? y_pts(ctrl, a_reg.b.seg) : x_pts(ctrl, a_reg.b.seg);
            b_next.b   = a_reg.b;
            b_next.mid = a_reg.mid;
            b_next.pr0 = PROD_W'(a_reg.w0) * PROD_W'(p.p0);
            b_next.pr1 = PROD_W'(a_reg.w1) * PROD_W'(p.p1);
            b_next.pr2 = PROD_W'(a_reg.w2) * PROD_W'(p.p2);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_vld_reg <= 1'b0;
                b_vld_reg <= 1'b0;
            end
            else if (adv)
            begin
                a_vld_reg <= stg_vld[s];
                b_vld_reg <= a_vld_reg;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                a_reg <= a_next;
                b_reg <= b_next;
            end
        end

        if (!IS_EVAL)
        begin : g_bisect
            logic c_vld_reg;
            bis_t c_reg, c_next;

            // keep the half whose x range still holds the sample
            always_comb
            begin
                logic [SUM_W-1:0] sum;
                logic [SUM_W-1:0] target;
                sum    = SUM_W'(b_reg.pr0) + SUM_W'(b_reg.pr1) + SUM_W'(b_reg.pr2);
                target = SUM_W'(b_reg.b.x) << T_FRAC;
                c_next = b_reg.b;
                if (sum < target)
                begin
                    c_next.low = b_reg.mid;
                end
                else
                begin
                    c_next.high = b_reg.mid;
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    c_vld_reg <= 1'b0;
                end
                else if (adv)
                begin
                    c_vld_reg <= b_vld_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    c_reg <= c_next;
                end
            end

            assign stg_vld[s+1] = c_vld_reg;
            assign stg_dat[s+1] = c_reg;
        end
        else
        begin : g_eval
            // y at the final midpoint, rounded half up
            always_comb
            begin
                logic [SUM_W-1:0] sum;
                sum = SUM_W'(b_reg.pr0) + SUM_W'(b_reg.pr1) + SUM_W'(b_reg.pr2)
                    + ROUND_HALF;
                out_data_next  = sum[T_FRAC +: Q_W];
                out_valid_next = b_vld_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

// ===== rtl/core/bezier_response_curve_unit.sv =====
`timescale 1ns / 1ps

// channel   dir  payload                 meaning
// cfg       in   index[2:0], data[16:0]  control register write, always ready
// sample    in   sample_in[16:0]         Q1.16 controller word
// result    out  shaped_out[16:0]        Q1.16 shaped word, one per sample
//
// one sample word enters per cycle and one result word leaves per cycle while results are taken
// a taken sample reaches its result word through the input register (loaded at the
//   accepting edge), one queue slot, three stages per bisection step (squares,
//   products, compare), two stages for the y evaluation and the output register
// reset clears all valid flags and loads the default curve
// a stalled result holds the back pipeline; the queue lets the front keep
//   taking samples until it fills

module bezier_response_curve_unit
    import brc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    brc_cfg_if.sink       cfg,
    brc_sample_if.sink    sample,
    brc_result_if.source  result
);

    // raw control registers
    logic [Q_W-1:0] start_y_reg;
    logic [Q_W-2:0] left_ctrl_x_reg;
    logic [Q_W-1:0] left_ctrl_y_reg;
    logic [Q_W-1:0] center_y_reg;
    logic [Q_W-1:0] right_ctrl_x_reg;
    logic [Q_W-1:0] right_ctrl_y_reg;
    logic [Q_W-1:0] end_y_reg;

    ctrl_t ctrl;

    // front to queue
    logic        f_valid;
    logic        f_ready;
    front_item_t f_item;

    // queue to back
    logic        q_valid;
    logic        q_ready;
    front_item_t q_item;

    assign cfg.ready = 1'b1;

    // register writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_y_reg      <= Q_W'(0);
            left_ctrl_x_reg  <= (Q_W-1)'(16384);
            left_ctrl_y_reg  <= Q_W'(16384);
            center_y_reg     <= Q_W'(32768);
            right_ctrl_x_reg <= Q_W'(49152);
            right_ctrl_y_reg <= Q_W'(49152);
            end_y_reg        <= Q_W'(65536);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_START_Y:      start_y_reg      <= cfg.data;
                CFG_LEFT_CTRL_X:  left_ctrl_x_reg  <= cfg.data[Q_W-2:0];
                CFG_LEFT_CTRL_Y:  left_ctrl_y_reg  <= cfg.data;
                CFG_CENTER_Y:     center_y_reg     <= cfg.data;
                CFG_RIGHT_CTRL_X: right_ctrl_x_reg <= cfg.data;
                CFG_RIGHT_CTRL_Y: right_ctrl_y_reg <= cfg.data;
                CFG_END_Y:        end_y_reg        <= cfg.data;
                default:          ;
            endcase
        end
    end

    // clamp controls into their bands; the user must keep them stable while items are in flight (not enforced here)
    always_comb
    begin
        ctrl.lcx = ({1'b0, left_ctrl_x_reg} > Q_HALF) ? Q_HALF : {1'b0, left_ctrl_x_reg};
        if (right_ctrl_x_reg < Q_HALF)
        begin
            ctrl.rcx = Q_HALF;
        end
        else if (right_ctrl_x_reg > Q_ONE)
        begin
            ctrl.rcx = Q_ONE;
        end
        else
        begin
            ctrl.rcx = right_ctrl_x_reg;
        end
        ctrl.sy = (start_y_reg > Q_ONE) ? Q_ONE : start_y_reg;
        ctrl.ly = (left_ctrl_y_reg > Q_ONE) ? Q_ONE : left_ctrl_y_reg;
        ctrl.cy = (center_y_reg > Q_ONE) ? Q_ONE : center_y_reg;
        ctrl.ry = (right_ctrl_y_reg > Q_ONE) ? Q_ONE : right_ctrl_y_reg;
        ctrl.ey = (end_y_reg > Q_ONE) ? Q_ONE : end_y_reg;
    end

    // saturate and pick segment
    brc_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    // decouples intake from the bisection pipeline
    brc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    // unrolled bisection and y evaluation
    brc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (q_valid),
        .in_ready (q_ready),
        .in_item  (q_item),
        .ctrl     (ctrl),
        .result   (result)
    );

endmodule
